>>> rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared types and codes of the positional list engine
// Request and response payloads, request codes, and the probe that walks the
// cell chain.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int PLE_CAPACITY = 32;

  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_DELETE = 3'd1;
  localparam logic [2:0] REQ_GET    = 3'd2;
  localparam logic [2:0] REQ_LOCATE = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;

  typedef struct packed {
    logic [2:0]          req_type;
    logic [5:0]          position;
    logic signed [31:0]  value_in;
  } req_t;

  typedef struct packed {
    logic                ok;
    logic signed [31:0]  value_out;
    logic [5:0]          found_position;
    logic [5:0]          list_length;
    logic                is_empty;
  } rsp_t;

  // Search token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic                valid;
    logic                locate;
    logic                hit;
    logic signed [31:0]  data;
    logic [5:0]          found;
  } probe_t;

  // Broadcast shift command for one commit cycle.
  typedef struct packed {
    logic                up;
    logic                down;
    logic [5:0]          pos;
    logic signed [31:0]  value;
  } shift_t;

endpackage

>>> rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell: one list slot
// Holds one element, shifts it with its neighbors on insert and delete, and
// passes the search probe on to the next cell, claiming it on a match.
// ----------------------------------------------------------------------------
module ple_cell import ple_pkg::*; #(
  parameter int CAPACITY = PLE_CAPACITY,
  parameter int INDEX    = 0,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  shift_t             shift,
  input  logic signed [31:0] left,
  input  logic signed [31:0] right,
  input  logic [CW-1:0]      count,
  input  logic [5:0]         key_pos,
  input  logic signed [31:0] key_value,
  input  probe_t             probe_in,
  output logic signed [31:0] data,
  output probe_t             probe_out
);

  localparam logic [5:0] FOUND_CODE = 6'(INDEX + 1);

  logic match_idx;
  logic match_val;
  logic take;

  assign match_idx = (int'(key_pos) == INDEX + 1);
  assign match_val = (INDEX < int'(count)) && (data == key_value);
  assign take      = probe_in.valid && !probe_in.hit &&
                     (probe_in.locate ? match_val : match_idx);

  // Element storage: no reset, slots above the length are never read.
  always_ff @(posedge clk) begin
    if (shift.up) begin
      if (int'(shift.pos) == INDEX + 1) begin
        data <= shift.value;
      end else if (int'(shift.pos) <= INDEX) begin
        data <= left;
      end
    end else if (shift.down) begin
      if (int'(shift.pos) <= INDEX + 1) begin
        data <= right;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
    end
    probe_out.locate <= probe_in.locate;
    probe_out.hit    <= probe_in.hit | take;
    probe_out.data   <= take ? data : probe_in.data;
    probe_out.found  <= take ? FOUND_CODE : probe_in.found;
  end

endmodule

>>> rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list of signed 32-bit elements
// A row of CAPACITY cells holds the list; insert, delete, get, locate, clear.
// ----------------------------------------------------------------------------
// Insert, clear and rejected requests: no pass along the chain; the response
//   is loaded from the finish state once the response register is free.
// Get, delete and locate: the probe crosses one cell per cycle along the chain,
//   and the response is loaded after it leaves the last cell.
// One request is in flight at a time; the next is taken once the response is
//   loaded. rst (synchronous) empties the list and drops any work.
module positional_list_engine import ple_pkg::*; #(
  parameter int CAPACITY = PLE_CAPACITY
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;

  // Request held for the whole operation.
  logic [2:0]         cur_type;
  logic [5:0]         cur_pos;
  logic signed [31:0] cur_value;

  // Result being assembled.
  logic               res_ok;
  logic signed [31:0] res_val;
  logic [5:0]         res_found;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic launch_valid;
  logic launch_locate;
  probe_t probe_w [CAPACITY+1];
  logic signed [31:0] data_w  [CAPACITY];
  logic signed [31:0] left_w  [CAPACITY];
  logic signed [31:0] right_w [CAPACITY];

  shift_t shift;

  logic accept;
  logic commit;
  logic ins_ok;
  logic idx_ok;
  logic start_scan;
  logic quick_ok;

  assign accept = req_valid && !req_stall;
  // Commit only once the response register is free.
  assign commit = (state == S_FINISH) && (!rsp_valid || !rsp_stall);

  assign req_stall = (state != S_IDLE);

  // Bounds checks against the current length.
  assign ins_ok = (int'(count) < CAPACITY) && (req.position != 6'd0) &&
                  (int'(req.position) <= int'(count) + 1);
  assign idx_ok = (req.position != 6'd0) && (int'(req.position) <= int'(count));

  // Decide whether the request needs a pass along the chain.
  always_comb begin
    start_scan = 1'b0;
    quick_ok   = 1'b0;
    unique case (req.req_type)
      REQ_INSERT: quick_ok = ins_ok;
      REQ_DELETE, REQ_GET: begin
        start_scan = idx_ok;
      end
      REQ_LOCATE: start_scan = 1'b1;
      REQ_CLEAR:  quick_ok = 1'b1;
      default:    quick_ok = 1'b0;
    endcase
  end

  // Length after this commit.
  always_comb begin
    count_next = count;
    case (cur_type)
      REQ_INSERT: if (res_ok) count_next = count + CW'(1);
      REQ_DELETE: if (res_ok) count_next = count - CW'(1);
      REQ_CLEAR:  count_next = '0;
      default:    count_next = count;
    endcase
  end

  // Broadcast shift to every cell on a successful insert or delete.
  always_comb begin
    shift.up    = commit && (cur_type == REQ_INSERT) && res_ok;
    shift.down  = commit && (cur_type == REQ_DELETE) && res_ok;
    shift.pos   = cur_pos;
    shift.value = cur_value;
  end

  // Probe entering the first cell: a fresh, unclaimed token.
  assign probe_w[0] = '{valid: launch_valid, locate: launch_locate, hit: 1'b0,
                        data: 32'sd0, found: 6'd0};

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign left_w[g] = cur_value;
      end else begin : g_mid
        assign left_w[g] = data_w[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_w[g] = data_w[g];
      end else begin : g_inner
        assign right_w[g] = data_w[g+1];
      end

      ple_cell #(
        .CAPACITY (CAPACITY),
        .INDEX    (g),
        .CW       (CW)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (shift),
        .left      (left_w[g]),
        .right     (right_w[g]),
        .count     (count),
        .key_pos   (cur_pos),
        .key_value (cur_value),
        .probe_in  (probe_w[g]),
        .data      (data_w[g]),
        .probe_out (probe_w[g+1])
      );
    end
  endgenerate

  // Request latch: payload only, no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_type  <= req.req_type;
      cur_pos   <= req.position;
      cur_value <= req.value_in;
    end
  end

  // Controller: state, length, probe launch and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      rsp_valid     <= 1'b0;
      launch_valid  <= 1'b0;
    end else begin
      // Launch a one-cycle probe pulse when a scan request transfers.
      launch_valid <= (state == S_IDLE) && accept && start_scan;
      // Load the response on commit; clear it once it transfers.
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_ok    <= quick_ok;
            res_val   <= '0;
            res_found <= '0;
            if (start_scan) begin
              state <= S_SCAN;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_SCAN: begin
          if (probe_w[CAPACITY].valid) begin
            res_ok    <= 1'b1;
            res_val   <= probe_w[CAPACITY].locate ? 32'sd0 : probe_w[CAPACITY].data;
            res_found <= probe_w[CAPACITY].locate ? probe_w[CAPACITY].found : 6'd0;
            state     <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (commit) begin
            count <= count_next;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Launch payload and response payload: no reset needed.
  always_ff @(posedge clk) begin
    launch_locate <= (req.req_type == REQ_LOCATE);
    if (commit) begin
      rsp.ok             <= res_ok;
      rsp.value_out      <= res_val;
      rsp.found_position <= res_found;
      rsp.list_length    <= 6'(count_next);
      rsp.is_empty       <= (count_next == '0);
    end
  end

endmodule
